### hw/rtl/dsc_pkg.sv
// shared types, codes and helper functions for diagnostic session control
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

   // inactivity timer width
   localparam int TIMER_WIDTH = 16;
   // timeout register width
   localparam int CSR_WIDTH = 16;
   // width that holds both the timeout register and the timer
   localparam int WIDE_WIDTH = (TIMER_WIDTH > CSR_WIDTH) ? TIMER_WIDTH : CSR_WIDTH;

   typedef logic [1:0]             func_type;
   typedef logic [2:0]             req_session_type;
   typedef logic [1:0]             session_type;
   typedef logic [1:0]             status_type;
   typedef logic [CSR_WIDTH-1:0]   csr_type;
   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [31:0]            count_type;

   // function codes
   localparam func_type FUNC_TICK      = 2'd0;
   localparam func_type FUNC_REQUEST   = 2'd1;
   localparam func_type FUNC_KEEPALIVE = 2'd2;

   // session codes
   localparam session_type SESS_DEFAULT = 2'd0;
   localparam session_type SESS_PROG    = 2'd1;
   localparam session_type SESS_EXT     = 2'd2;
   localparam session_type SESS_SAFETY  = 2'd3;

   // highest valid requested session code
   localparam req_session_type REQ_MAX = 3'd3;

   // status codes
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_REFUSED = 2'd2;
   localparam status_type ST_TIMEOUT = 2'd3;

   // timeout after reset
   localparam csr_type S3_RESET = CSR_WIDTH'(5000);

   // timeout clipped to what the timer can hold
   function automatic timer_type reload_value(input csr_type s3);
      logic [WIDE_WIDTH-1:0] s3_wide;
      logic [WIDE_WIDTH-1:0] max_wide;
      s3_wide  = WIDE_WIDTH'(s3);
      max_wide = WIDE_WIDTH'({TIMER_WIDTH{1'b1}});
      if (s3_wide > max_wide) begin
         return TIMER_WIDTH'(max_wide);
      end
      return TIMER_WIDTH'(s3_wide);
   endfunction

   // session transition matrix
   function automatic logic transition_allowed(input session_type from, input session_type to);
      logic ok;
      ok = 1'b0;
      if (to == SESS_DEFAULT) begin
         ok = 1'b1;
      end else begin
         case (from)
            SESS_DEFAULT: ok = 1'b1;
            SESS_PROG:    ok = (to == SESS_PROG);
            SESS_EXT:     ok = (to == SESS_EXT) || (to == SESS_PROG);
            SESS_SAFETY:  ok = (to == SESS_SAFETY);
            default:      ok = 1'b0;
         endcase
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/diagnostic_session_control.sv
// diagnostic session control: session state, inactivity timer and change count
//
//   channel  ports                                     direction  role
//   req      req_valid/ready, func, requested_session  in         tick, request, keepalive
//   rsp      rsp_valid/ready, status ... change_count  out        one result per item
//   csr      csr_valid/ready, csr_s3_timeout           in         timeout write, reloads timer
//
// One item per clock sustained while rsp_ready holds; a result passes through the input
// register, then the result register, set by the single update of the state registers.
// Reset gives the default session, a 5000-tick timeout, a timer loaded with it and a zero count.
// A stalled result holds in the result register while one more item waits in the input register.
// The timeout port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module diagnostic_session_control (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire dsc_pkg::func_type        req_func,
   input  wire dsc_pkg::req_session_type req_requested_session,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      dsc_pkg::status_type      rsp_status,
   output      dsc_pkg::session_type     rsp_session,
   output      logic                     rsp_is_default,
   output      logic                     rsp_session_changed,
   output      dsc_pkg::session_type     rsp_previous_session,
   output      dsc_pkg::count_type       rsp_change_count,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire dsc_pkg::csr_type         csr_s3_timeout
);
   import dsc_pkg::*;

   // input register
   logic            in_valid_ff;
   func_type        in_func_ff;
   req_session_type in_req_ff;

   // state
   csr_type     s3_ff;
   session_type session_ff;
   session_type session_in;
   timer_type   timer_ff;
   timer_type   timer_in;
   count_type   count_ff;
   count_type   count_in;

   // result register
   logic        out_valid_ff;
   status_type  status_ff;
   status_type  status_in;
   session_type active_ff;
   logic        is_default_ff;
   logic        changed_ff;
   logic        changed_in;
   session_type previous_ff;
   count_type   out_count_ff;

   logic      advance;
   timer_type timer_dec;
   timer_type reload;

   // pipeline moves when the result register is free or being taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign reload    = reload_value(s3_ff);
   assign timer_dec = (timer_ff != '0) ? timer_ff - 1'b1 : timer_ff;

   // next state and result for the held item
   always_comb begin
      session_in = session_ff;
      timer_in   = timer_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      changed_in = 1'b0;
      case (in_func_ff)
         FUNC_TICK: begin
            if (session_ff != SESS_DEFAULT) begin
               timer_in = timer_dec;
               if (timer_dec == '0) begin
                  session_in = SESS_DEFAULT;
                  timer_in   = reload;
                  status_in  = ST_TIMEOUT;
                  changed_in = 1'b1;
               end
            end
         end
         FUNC_REQUEST: begin
            if (in_req_ff > REQ_MAX) begin
               status_in = ST_INVALID;
            end else if (!transition_allowed(session_ff, in_req_ff[1:0])) begin
               status_in = ST_REFUSED;
            end else begin
               session_in = in_req_ff[1:0];
               timer_in   = reload;
               count_in   = count_ff + 1'b1;
               changed_in = 1'b1;
            end
         end
         FUNC_KEEPALIVE: begin
            timer_in = reload;
         end
         default: begin
            session_in = session_ff;
         end
      endcase
   end

   // input register transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_req_ff  <= req_requested_session;
      end
   end

   // state update and timeout writes
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff      <= S3_RESET;
         session_ff <= SESS_DEFAULT;
         timer_ff   <= reload_value(S3_RESET);
         count_ff   <= '0;
      end else begin
         if (advance && in_valid_ff) begin
            session_ff <= session_in;
            timer_ff   <= timer_in;
            count_ff   <= count_in;
         end
         if (csr_valid && csr_ready) begin
            s3_ff    <= csr_s3_timeout;
            timer_ff <= reload_value(csr_s3_timeout);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance && in_valid_ff) begin
         status_ff     <= status_in;
         active_ff     <= session_in;
         is_default_ff <= (session_in == SESS_DEFAULT);
         changed_ff    <= changed_in;
         previous_ff   <= session_ff;
         out_count_ff  <= count_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_session          = active_ff;
   assign rsp_is_default       = is_default_ff;
   assign rsp_session_changed  = changed_ff;
   assign rsp_previous_session = previous_ff;
   assign rsp_change_count     = out_count_ff;

   // a timeout result always lands in default, coming from elsewhere
   a_timeout_to_default: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (status_ff == ST_TIMEOUT) |->
         changed_ff && (active_ff == SESS_DEFAULT) && (previous_ff != SESS_DEFAULT))
      else $error("timeout result without a return to default");

   // no change means the session stayed put
   a_unchanged_session: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !changed_ff |-> (active_ff == previous_ff))
      else $error("session moved without a change notification");

   // refused or invalid requests leave the state alone
   a_rejected_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff && ((status_in == ST_INVALID) || (status_in == ST_REFUSED))
         |=> $stable(session_ff) && $stable(count_ff))
      else $error("rejected request changed session or count");

   // the count moves only with an accepted request
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) && !$past(reset) |->
         $past(advance && in_valid_ff && (in_func_ff == FUNC_REQUEST) && changed_in))
      else $error("change count moved without an accepted request");

endmodule

`default_nettype wire
